// ----- design/pdsft_pkg.sv -----
// Package for the prime digit-sum frequency table unit.
// Holds opcodes, status codes, controller/datapath command and status structs
// and the prime lookup mask. No dependencies.
package pdsft_pkg;

   // Request opcodes
   localparam logic [1:0] OP_OFFER = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // Width of the digit-sum accumulator (covers values up to 63 bits)
   localparam int SUM_BITS = 8;

   // Response status codes
   typedef enum logic [2:0] {
      ST_REJECTED = 3'd0,
      ST_COUNTED  = 3'd1,
      ST_INSERTED = 3'd2,
      ST_DROPPED  = 3'd3,
      ST_READ_OK  = 3'd4,
      ST_READ_OOR = 3'd5,
      ST_CLEARED  = 3'd6
   } status_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic       accept;
      logic       dd_step;
      logic       sum_step;
      logic       bs_init;
      logic       bs_issue;
      logic       bs_eval;
      logic       find_issue;
      logic       sh_init;
      logic       sh_issue;
      logic       sh_write;
      logic       put_new;
      logic       put_count;
      logic       rd_issue;
      logic       clear;
      logic       set_res;
      status_type res_status;
      logic       send;
   } dp_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic dd_last;
      logic sum_last;
      logic prime;
      logic lo_lt_hi;
      logic hit;
      logic full;
      logic cur_gt_lo;
      logic index_ok;
      logic rsp_free;
   } dp_sts_type;

   // Sieve for primes below 2**SUM_BITS, worked out at elaboration
   function automatic logic [255:0] prime_mask_f();
      logic [255:0] m;
      int           i;
      int           j;
      m = '1;
      m[0] = 1'b0;
      m[1] = 1'b0;
      for (i = 2; i < 16; i++) begin
         if (m[i]) begin
            for (j = i * i; j < 256; j += i) begin
               m[j] = 1'b0;
            end
         end
      end
      return m;
   endfunction

   localparam logic [255:0] PRIME_MASK = prime_mask_f();

endpackage

// ----- design/prime_digit_sum_frequency_table_unit.sv -----
// Prime digit-sum frequency table unit: top level.
// Uses pdsft_pkg, pdsft_ctrl and pdsft_dp (which holds pdsft_ram).
//
// Usage:
//  The req_ channel carries an opcode (offer, read, clear), a value and an
//  index; a transfer occurs when req_valid is high and req_stall low. Each
//  item produces exactly one rsp_ transfer with status, position, entry value,
//  entry count and the number of entries held after the item.
//  Items are handled one at a time. A clear, an out-of-range read or an
//  unused opcode goes straight to its result; an in-range read first reads
//  the entry RAM. An offer runs a bit-serial BCD conversion, a digit sum and
//  a prime check; if the sum is prime it does a binary search (at most
//  clog2(ENTRIES+1) probes, each a RAM read and an evaluation), then counts,
//  drops or inserts, an insert moving each entry above the slot up by one.
//  The next item is taken the cycle after the send.
//  Reset (synchronous, active high) empties the table and drops any pending
//  response; entry storage is not cleared. The response sits in an output
//  register: while rsp_stall is high it holds, and the next item may still
//  be taken and worked on up to the point where its result is ready.
module prime_digit_sum_frequency_table_unit #(
   parameter int ENTRIES    = 64,
   parameter int VALUE_BITS = 31,
   parameter int COUNT_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_opcode,
   input  logic [VALUE_BITS-1:0]        req_value,
   input  logic [$clog2(ENTRIES)-1:0]   req_index,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [2:0]                   rsp_status,
   output logic [$clog2(ENTRIES)-1:0]   rsp_position,
   output logic [VALUE_BITS-1:0]        rsp_entry_value,
   output logic [COUNT_BITS-1:0]        rsp_entry_count,
   output logic [$clog2(ENTRIES+1)-1:0] rsp_entries_used
);
   import pdsft_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   // Sequencer
   pdsft_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Datapath and table storage
   pdsft_dp #(
      .ENTRIES    (ENTRIES),
      .VALUE_BITS (VALUE_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_value        (req_value),
      .req_index        (req_index),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_position     (rsp_position),
      .rsp_entry_value  (rsp_entry_value),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_entries_used (rsp_entries_used)
   );

endmodule

// ----- design/pdsft_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pdsft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/pdsft_dp.sv -----
// Datapath: digit-sum unit, binary search and shift over the entry RAM,
// result and response registers. Uses pdsft_pkg and pdsft_ram.
module pdsft_dp #(
   parameter int ENTRIES    = 64,
   parameter int VALUE_BITS = 31,
   parameter int COUNT_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  pdsft_pkg::dp_cmd_type            cmd,
   output pdsft_pkg::dp_sts_type            sts,
   input  logic [VALUE_BITS-1:0]            req_value,
   input  logic [$clog2(ENTRIES)-1:0]       req_index,
   input  logic                             rsp_stall,
   output logic                             rsp_valid,
   output logic [2:0]                       rsp_status,
   output logic [$clog2(ENTRIES)-1:0]       rsp_position,
   output logic [VALUE_BITS-1:0]            rsp_entry_value,
   output logic [COUNT_BITS-1:0]            rsp_entry_count,
   output logic [$clog2(ENTRIES+1)-1:0]     rsp_entries_used
);
   import pdsft_pkg::*;

   localparam int AW     = $clog2(ENTRIES);
   localparam int UW     = $clog2(ENTRIES + 1);
   localparam int DIGITS = (VALUE_BITS * 3) / 10 + 1;
   localparam int BW     = 4 * DIGITS;
   localparam int SCW    = $clog2(VALUE_BITS + 1);
   localparam int WW     = VALUE_BITS + COUNT_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [AW-1:0]         index_ff, index_in;
   logic [VALUE_BITS-1:0] bin_ff, bin_in;
   logic [BW-1:0]         bcd_ff, bcd_in;
   logic [SCW-1:0]        step_ff, step_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [UW-1:0]         lo_ff, lo_in, hi_ff, hi_in, cur_ff, cur_in, used_ff, used_in;
   status_type            res_status_ff, res_status_in;
   logic [AW-1:0]         res_pos_ff, res_pos_in;
   logic [VALUE_BITS-1:0] res_val_ff, res_val_in;
   logic [COUNT_BITS-1:0] res_cnt_ff, res_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [2:0]            rsp_status_ff, rsp_status_in;
   logic [AW-1:0]         rsp_pos_ff, rsp_pos_in;
   logic [VALUE_BITS-1:0] rsp_val_ff, rsp_val_in;
   logic [COUNT_BITS-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic [UW-1:0]         rsp_used_ff, rsp_used_in;

   logic [UW:0]           mid_sum;
   logic [UW-1:0]         mid;
   logic [UW-1:0]         cur_m1;
   logic [WW-1:0]         rdata;
   logic [VALUE_BITS-1:0] rd_val;
   logic [COUNT_BITS-1:0] rd_cnt;
   logic [COUNT_BITS-1:0] cnt_inc;
   logic [BW-1:0]         bcd_adj;
   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   logic [WW-1:0]         ram_wdata;
   logic [AW-1:0]         ram_raddr;
   logic                  rsp_free;

   // Search helpers and read data split
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[UW:1];
   assign cur_m1  = cur_ff - UW'(1);
   assign rd_val  = rdata[WW-1:COUNT_BITS];
   assign rd_cnt  = rdata[COUNT_BITS-1:0];
   assign cnt_inc = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Double-dabble digit correction, one per BCD digit
   always_comb begin
      for (int d = 0; d < DIGITS; d++) begin
         bcd_adj[4*d +: 4] = (bcd_ff[4*d +: 4] >= 4'd5) ? bcd_ff[4*d +: 4] + 4'd3
                                                          : bcd_ff[4*d +: 4];
      end
   end

   // Entry RAM port selection
   always_comb begin
      priority if (cmd.rd_issue) begin
         ram_raddr = req_index;
      end else if (cmd.bs_issue) begin
         ram_raddr = mid[AW-1:0];
      end else if (cmd.sh_issue) begin
         ram_raddr = cur_m1[AW-1:0];
      end else begin
         ram_raddr = lo_ff[AW-1:0];
      end
      ram_we = cmd.put_count || cmd.put_new || cmd.sh_write;
      priority if (cmd.sh_write) begin
         ram_waddr = cur_ff[AW-1:0];
         ram_wdata = rdata;
      end else if (cmd.put_count) begin
         ram_waddr = lo_ff[AW-1:0];
         ram_wdata = {value_ff, cnt_inc};
      end else begin
         ram_waddr = lo_ff[AW-1:0];
         ram_wdata = {value_ff, COUNT_BITS'(1)};
      end
   end

   pdsft_ram #(
      .WIDTH (WW),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (rdata)
   );

   // Next-state logic for the working registers
   always_comb begin
      value_in      = value_ff;
      index_in      = index_ff;
      bin_in        = bin_ff;
      bcd_in        = bcd_ff;
      step_in       = step_ff;
      sum_in        = sum_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      cur_in        = cur_ff;
      used_in       = used_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      res_val_in    = res_val_ff;
      res_cnt_in    = res_cnt_ff;

      if (cmd.accept) begin
         value_in = req_value;
         index_in = req_index;
         bin_in   = req_value;
         bcd_in   = '0;
         step_in  = '0;
      end
      if (cmd.dd_step) begin
         bcd_in = {bcd_adj[BW-2:0], bin_ff[VALUE_BITS-1]};
         bin_in = {bin_ff[VALUE_BITS-2:0], 1'b0};
         if (sts.dd_last) begin
            step_in = '0;
            sum_in  = '0;
         end else begin
            step_in = step_ff + SCW'(1);
         end
      end
      if (cmd.sum_step) begin
         sum_in  = sum_ff + SUM_BITS'(bcd_ff[3:0]);
         bcd_in  = {4'b0, bcd_ff[BW-1:4]};
         step_in = step_ff + SCW'(1);
      end
      if (cmd.bs_init) begin
         lo_in = '0;
         hi_in = used_ff;
      end
      if (cmd.bs_eval) begin
         if (rd_val < value_ff) begin
            lo_in = mid + UW'(1);
         end else begin
            hi_in = mid;
         end
      end
      if (cmd.sh_init) begin
         cur_in = used_ff;
      end
      if (cmd.sh_write) begin
         cur_in = cur_m1;
      end
      if (cmd.clear) begin
         used_in = '0;
      end
      if (cmd.put_new) begin
         used_in = used_ff + UW'(1);
      end
      if (cmd.set_res) begin
         res_status_in = cmd.res_status;
         unique case (cmd.res_status)
            ST_COUNTED: begin
               res_pos_in = lo_ff[AW-1:0];
               res_val_in = value_ff;
               res_cnt_in = cnt_inc;
            end
            ST_INSERTED: begin
               res_pos_in = lo_ff[AW-1:0];
               res_val_in = value_ff;
               res_cnt_in = COUNT_BITS'(1);
            end
            ST_READ_OK: begin
               res_pos_in = index_ff;
               res_val_in = rd_val;
               res_cnt_in = rd_cnt;
            end
            default: begin
               res_pos_in = '0;
               res_val_in = '0;
               res_cnt_in = '0;
            end
         endcase
      end
   end

   // Output register: loaded on send, emptied on transfer
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_val_in    = rsp_val_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_used_in   = rsp_used_ff;
      if (cmd.send) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_pos_in    = res_pos_ff;
         rsp_val_in    = res_val_ff;
         rsp_cnt_in    = res_cnt_ff;
         rsp_used_in   = used_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      value_ff      <= value_in;
      index_ff      <= index_in;
      bin_ff        <= bin_in;
      bcd_ff        <= bcd_in;
      step_ff       <= step_in;
      sum_ff        <= sum_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      cur_ff        <= cur_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      res_val_ff    <= res_val_in;
      res_cnt_ff    <= res_cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_val_ff    <= rsp_val_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_used_ff   <= rsp_used_in;
   end

   // Status to the controller
   always_comb begin
      sts.dd_last   = (step_ff == SCW'(VALUE_BITS - 1));
      sts.sum_last  = (step_ff == SCW'(DIGITS - 1));
      sts.prime     = PRIME_MASK[sum_ff];
      sts.lo_lt_hi  = (lo_ff < hi_ff);
      sts.hit       = (lo_ff < used_ff) && (rd_val == value_ff);
      sts.full      = (used_ff == UW'(ENTRIES));
      sts.cur_gt_lo = (cur_ff > lo_ff);
      sts.index_ok  = (UW'(req_index) < used_ff);
      sts.rsp_free  = rsp_free;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_position     = rsp_pos_ff;
   assign rsp_entry_value  = rsp_val_ff;
   assign rsp_entry_count  = rsp_cnt_ff;
   assign rsp_entries_used = rsp_used_ff;

endmodule

// ----- design/pdsft_ctrl.sv -----
// Controller state machine: sequences digit sum, search, count, insert,
// read and clear. Uses pdsft_pkg; drives the datapath by command struct.
module pdsft_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_opcode,
   output logic                  req_stall,
   input  pdsft_pkg::dp_sts_type sts,
   output pdsft_pkg::dp_cmd_type cmd
);
   import pdsft_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE    = 11'b000_0000_0001,
      S_DD      = 11'b000_0000_0010,
      S_DSUM    = 11'b000_0000_0100,
      S_CHK     = 11'b000_0000_1000,
      S_BS_RD   = 11'b000_0001_0000,
      S_BS_EV   = 11'b000_0010_0000,
      S_FIND_EV = 11'b000_0100_0000,
      S_SH_RD   = 11'b000_1000_0000,
      S_SH_WR   = 11'b001_0000_0000,
      S_RD_EV   = 11'b010_0000_0000,
      S_DONE    = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // Next state and command decode
   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               priority if (req_opcode == OP_OFFER) begin
                  state_in = S_DD;
               end else if (req_opcode == OP_READ) begin
                  if (sts.index_ok) begin
                     cmd.rd_issue = 1'b1;
                     state_in     = S_RD_EV;
                  end else begin
                     cmd.set_res    = 1'b1;
                     cmd.res_status = ST_READ_OOR;
                     state_in       = S_DONE;
                  end
               end else if (req_opcode == OP_CLEAR) begin
                  cmd.clear      = 1'b1;
                  cmd.set_res    = 1'b1;
                  cmd.res_status = ST_CLEARED;
                  state_in       = S_DONE;
               end else begin
                  cmd.set_res    = 1'b1;
                  cmd.res_status = ST_REJECTED;
                  state_in       = S_DONE;
               end
            end
         end
         S_DD: begin
            cmd.dd_step = 1'b1;
            if (sts.dd_last) begin
               state_in = S_DSUM;
            end
         end
         S_DSUM: begin
            cmd.sum_step = 1'b1;
            if (sts.sum_last) begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (sts.prime) begin
               cmd.bs_init = 1'b1;
               state_in    = S_BS_RD;
            end else begin
               cmd.set_res    = 1'b1;
               cmd.res_status = ST_REJECTED;
               state_in       = S_DONE;
            end
         end
         S_BS_RD: begin
            if (sts.lo_lt_hi) begin
               cmd.bs_issue = 1'b1;
               state_in     = S_BS_EV;
            end else begin
               cmd.find_issue = 1'b1;
               state_in       = S_FIND_EV;
            end
         end
         S_BS_EV: begin
            cmd.bs_eval = 1'b1;
            state_in    = S_BS_RD;
         end
         S_FIND_EV: begin
            cmd.set_res = 1'b1;
            priority if (sts.hit) begin
               cmd.put_count  = 1'b1;
               cmd.res_status = ST_COUNTED;
               state_in       = S_DONE;
            end else if (sts.full) begin
               cmd.res_status = ST_DROPPED;
               state_in       = S_DONE;
            end else begin
               cmd.set_res = 1'b0;
               cmd.sh_init = 1'b1;
               state_in    = S_SH_RD;
            end
         end
         S_SH_RD: begin
            if (sts.cur_gt_lo) begin
               cmd.sh_issue = 1'b1;
               state_in     = S_SH_WR;
            end else begin
               cmd.put_new    = 1'b1;
               cmd.set_res    = 1'b1;
               cmd.res_status = ST_INSERTED;
               state_in       = S_DONE;
            end
         end
         S_SH_WR: begin
            cmd.sh_write = 1'b1;
            state_in     = S_SH_RD;
         end
         S_RD_EV: begin
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_READ_OK;
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.send = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   // Every accepted item leaves the idle state
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("accepted item did not leave idle");

   // A response is only sent into a free output register
   a_send_free: assert property (@(posedge clock) disable iff (reset)
      cmd.send |-> sts.rsp_free)
      else $error("response sent while output register busy");

   // A new entry is never written into a full table
   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      cmd.put_new |-> !sts.full)
      else $error("insert into full table");
`endif

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for prime_digit_sum_frequency_table_unit.
// Depends on pdsft_pkg and the unit's RTL; it predicts every response from its own table model.
module tb_top;
   import pdsft_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES    = 64;
   localparam int VALUE_BITS = 31;
   localparam int COUNT_BITS = 16;
   localparam int IDX_BITS   = $clog2(ENTRIES);
   localparam int USED_BITS  = $clog2(ENTRIES + 1);
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      status_type             status;
      logic [IDX_BITS-1:0]    position;
      logic [VALUE_BITS-1:0]  entry_value;
      logic [COUNT_BITS-1:0]  entry_count;
      logic [USED_BITS-1:0]   entries_used;
   } table_rsp_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [1:0]              req_opcode;
   logic [VALUE_BITS-1:0]   req_value;
   logic [IDX_BITS-1:0]     req_index;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [2:0]              rsp_status;
   logic [IDX_BITS-1:0]     rsp_position;
   logic [VALUE_BITS-1:0]   rsp_entry_value;
   logic [COUNT_BITS-1:0]   rsp_entry_count;
   logic [USED_BITS-1:0]    rsp_entries_used;

   // Predicted table contents
   logic [VALUE_BITS-1:0]   model_values [ENTRIES];
   logic [COUNT_BITS-1:0]   model_counts [ENTRIES];
   int                      model_used;

   table_rsp_type           pending_rsps[$];
   logic [VALUE_BITS-1:0]   value_pool[$];
   int                      mismatches;
   int                      rsp_seen;
   int                      status_seen [8];
   int                      send_idle_pct;
   int                      recv_stall_pct;

   prime_digit_sum_frequency_table_unit #(
      .ENTRIES    (ENTRIES),
      .VALUE_BITS (VALUE_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_value        (req_value),
      .req_index        (req_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_position     (rsp_position),
      .rsp_entry_value  (rsp_entry_value),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_entries_used (rsp_entries_used)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   initial begin
      #50ms;
      $display("timeout with %0d responses outstanding", pending_rsps.size());
      $display("Regression FAIL");
      $finish;
   end

   // Decimal digit sum of a value
   function automatic int digit_sum(logic [VALUE_BITS-1:0] v);
      int s;
      s = 0;
      while (v != 0) begin
         s += int'(v % 10);
         v = v / 10;
      end
      return s;
   endfunction

   function automatic bit sum_is_prime(logic [VALUE_BITS-1:0] v);
      int s;
      s = digit_sum(v);
      if (s < 2) return 1'b0;
      for (int d = 2; d * d <= s; d++) begin
         if (s % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Random value whose digit sum is prime, bounded by a mask
   function automatic logic [VALUE_BITS-1:0] prime_sum_value(logic [VALUE_BITS-1:0] mask);
      logic [VALUE_BITS-1:0] v;
      v = VALUE_BITS'($urandom()) & mask;
      while (!sum_is_prime(v)) v = VALUE_BITS'($urandom()) & mask;
      return v;
   endfunction

   // Table update for one accepted item; returns the response it must give
   function automatic table_rsp_type update_table(logic [1:0] op, logic [VALUE_BITS-1:0] v,
                                                  logic [IDX_BITS-1:0] idx);
      table_rsp_type r;
      int            slot;
      r.status = ST_REJECTED;
      r.position = '0;
      r.entry_value = '0;
      r.entry_count = '0;
      unique case (op)
         OP_OFFER: begin
            if (sum_is_prime(v)) begin
               slot = model_used;
               for (int i = model_used - 1; i >= 0; i--) begin
                  if (model_values[i] >= v) slot = i;
               end
               if (slot < model_used && model_values[slot] == v) begin
                  if (model_counts[slot] != '1) model_counts[slot]++;
                  r.status = ST_COUNTED;
                  r.position = slot[IDX_BITS-1:0];
                  r.entry_value = v;
                  r.entry_count = model_counts[slot];
               end else if (model_used >= ENTRIES) begin
                  r.status = ST_DROPPED;
               end else begin
                  for (int i = model_used; i > slot; i--) begin
                     model_values[i] = model_values[i-1];
                     model_counts[i] = model_counts[i-1];
                  end
                  model_values[slot] = v;
                  model_counts[slot] = COUNT_BITS'(1);
                  model_used++;
                  r.status = ST_INSERTED;
                  r.position = slot[IDX_BITS-1:0];
                  r.entry_value = v;
                  r.entry_count = COUNT_BITS'(1);
               end
            end
         end
         OP_READ: begin
            if (int'(idx) < model_used) begin
               r.status = ST_READ_OK;
               r.position = idx;
               r.entry_value = model_values[idx];
               r.entry_count = model_counts[idx];
            end else begin
               r.status = ST_READ_OOR;
            end
         end
         OP_CLEAR: begin
            model_used = 0;
            r.status = ST_CLEARED;
         end
         default: ;
      endcase
      r.entries_used = model_used[USED_BITS-1:0];
      return r;
   endfunction

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Response checker: every transfer against the oldest prediction
   always @(posedge clock) begin
      table_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         status_seen[rsp_status]++;
         if (pending_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%t: unexpected response, status %0d", $realtime, rsp_status);
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_status != want.status || rsp_position != want.position ||
                rsp_entry_value != want.entry_value ||
                rsp_entry_count != want.entry_count ||
                rsp_entries_used != want.entries_used) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"%t: mismatch exp st=%0d pos=%0d val=%0d cnt=%0d used=%0d,",
                            " got st=%0d pos=%0d val=%0d cnt=%0d used=%0d"},
                           $realtime, want.status, want.position, want.entry_value,
                           want.entry_count, want.entries_used, rsp_status, rsp_position,
                           rsp_entry_value, rsp_entry_count, rsp_entries_used);
            end
         end
      end
   end

   // One input transfer, with random idle cycles before it; valid stays high afterwards
   task automatic send_item(logic [1:0] op, logic [VALUE_BITS-1:0] v, logic [IDX_BITS-1:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_opcode <= 2'($urandom());
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_value  <= v;
      req_index  <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rsps.push_back(update_table(op, v, idx));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsps.size() != 0) @(posedge clock);
   endtask

   // Field extremes, every opcode and the rejected/out-of-range cases
   task automatic test_directed();
      send_item(OP_READ, '0, '0);                       // read of empty table
      send_item(OP_OFFER, '0, '1);                      // sum 0 is rejected
      send_item(OP_OFFER, 1, '0);                       // sum 1 is rejected
      send_item(OP_OFFER, 2, '0);
      send_item(OP_OFFER, 11, '0);
      send_item(OP_OFFER, 11, '0);                      // counted
      send_item(OP_OFFER, '1, '0);                      // max value, sum 46 rejected
      send_item(OP_OFFER, 31'd1099999999, '0);          // sum 73, largest slot
      send_item(OP_OFFER, 5, '0);                       // lands between entries
      send_item(OP_READ, '0, 0);
      send_item(OP_READ, '0, 3);
      send_item(OP_READ, '0, 4);                        // just past the end
      send_item(OP_READ, '1, '1);
      send_item(OP_UNUSED, 31'd11, '1);                 // unused opcode changes nothing
      send_item(OP_READ, '0, 2);
      send_item(OP_CLEAR, '1, '1);
      send_item(OP_READ, '0, 0);
      send_item(OP_OFFER, 31'd1099999999, '0);
      send_item(OP_READ, '0, 0);
      drain();
   endtask

   // Fill every slot in descending order, then overflow
   task automatic test_fill_and_drop();
      logic [VALUE_BITS-1:0] fill[$];
      logic [VALUE_BITS-1:0] v;
      send_item(OP_CLEAR, '0, '0);
      v = 2;
      while (fill.size() < ENTRIES + 1) begin
         if (sum_is_prime(v)) fill.push_front(VALUE_BITS'(v * 1000));
         v++;
      end
      for (int i = 1; i < fill.size(); i++) send_item(OP_OFFER, fill[i], '0);
      send_item(OP_OFFER, fill[0], '0);                 // table full: dropped
      send_item(OP_OFFER, fill[5], '0);                 // present: still counted
      send_item(OP_READ, '0, 0);
      send_item(OP_READ, '0, IDX_BITS'(ENTRIES - 1));
      drain();
      send_item(OP_CLEAR, '0, '0);
      drain();
   endtask

   // Mostly offers from a reusable pool so entries repeat and the table fills
   task automatic test_random(int n);
      int pick;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(99);
         if (pick < 55)
            send_item(OP_OFFER, value_pool[$urandom_range(value_pool.size() - 1)],
                      IDX_BITS'($urandom()));
         else if (pick < 65)
            send_item(OP_OFFER, prime_sum_value('1), IDX_BITS'($urandom()));
         else if (pick < 72)
            send_item(OP_OFFER, VALUE_BITS'($urandom()), IDX_BITS'($urandom()));
         else if (pick < 92)
            send_item(OP_READ, VALUE_BITS'($urandom()), IDX_BITS'($urandom()));
         else if (pick < 94)
            send_item(OP_CLEAR, VALUE_BITS'($urandom()), IDX_BITS'($urandom()));
         else if (pick < 96)
            send_item(OP_UNUSED, VALUE_BITS'($urandom()), IDX_BITS'($urandom()));
         else
            send_item(OP_OFFER, VALUE_BITS'($urandom_range(300)), IDX_BITS'($urandom()));
      end
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_OFFER;
      req_value = '0;
      req_index = '0;
      rsp_stall = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      mismatches = 0;
      rsp_seen = 0;
      model_used = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < 90; i++)
         value_pool.push_back(prime_sum_value(i < 30 ? 31'h3FF : '1));

      test_directed();
      test_fill_and_drop();
      test_random(400);
      send_idle_pct = 64;
      test_random(400);
      send_idle_pct = 0;
      recv_stall_pct = 64;
      test_random(400);
      send_idle_pct = 30;
      recv_stall_pct = 30;
      test_random(350);
      send_idle_pct = 0;
      recv_stall_pct = 0;

      repeat (200) @(posedge clock);
      $display("%0d responses checked: %0d inserted, %0d counted, %0d dropped, %0d rejected,",
               rsp_seen, status_seen[ST_INSERTED], status_seen[ST_COUNTED],
               status_seen[ST_DROPPED], status_seen[ST_REJECTED]);
      $display("%0d reads in range, %0d out of range, %0d clears; %0d mismatches",
               status_seen[ST_READ_OK], status_seen[ST_READ_OOR], status_seen[ST_CLEARED],
               mismatches);
      if (mismatches == 0 && pending_rsps.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
